[hw/rtl/pfb_pkg.sv]
package pfb_pkg;

  // default geometry and queue size
  localparam int unsigned DEF_PANEL_WIDTH  = 128;
  localparam int unsigned DEF_PANEL_HEIGHT = 64;
  localparam int unsigned DEF_QUEUE_DEPTH  = 4;

  // command kinds as they arrive on the input channel
  localparam logic [2:0] KIND_PIXEL       = 3'd0;
  localparam logic [2:0] KIND_SEG_TRANSP  = 3'd1;
  localparam logic [2:0] KIND_SEG_OPAQUE  = 3'd2;
  localparam logic [2:0] KIND_FILL        = 3'd3;
  localparam logic [2:0] KIND_READ        = 3'd4;

  // register index, taken from paddr bit 2
  localparam logic REG_INVERT_COLORS = 1'b0;

  localparam logic [15:0] FIRST_PIXEL = 16'h8000;
  localparam logic [4:0]  MAX_SPAN    = 5'd16;
  localparam logic [7:0]  FILL_WHITE  = 8'hFF;
  localparam logic [7:0]  FILL_BLACK  = 8'h00;

  typedef enum logic [1:0] {
    OP_SEG,
    OP_FILL,
    OP_READ,
    OP_NOP
  } op_e;

  // classified command, front to back
  typedef struct packed {
    op_e        op;
    logic       opaque;
    logic       color;
    logic [15:0] pattern;
    logic [4:0] span;
    logic [7:0] x;
    logic [2:0] page;
    logic [2:0] row_bit;
    logic       off;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEG,
    ST_READ,
    ST_FILL,
    ST_FIN
  } back_state_e;

endpackage

[hw/rtl/page_framebuffer_draw_engine_top.sv]
// page-layout monochrome frame store with a small drawing engine
//
// input channel (in_valid_i / in_ready_o): one word is one drawing command,
// kind_i selects pixel, transparent run, opaque run, fill or byte read
// output channel (out_valid_o / out_ready_i): exactly one result word per
// command, in command order; byte_read_o is the stored byte for a read,
// else zero, clipped_o flags any painted pixel or read off the panel
// apb port: one register at address 0, bit 0 is invert_colors
//
// a front end classifies commands into a small queue; the back end owns
// the store and runs one column byte read-modify-write per cycle
// the store has a single write port
// the front keeps taking words while the back end works or a result waits,
// as long as the queue has room
// reset: after rst_ni rises the store is cleared to black, one byte a cycle
// (PANEL_WIDTH*pages bytes, 1024 by default); in_ready_o stays low meanwhile
// receiver stall: the result register holds, the back end parks, and the
// queue fills until in_ready_o drops
module page_framebuffer_draw_engine_top import pfb_pkg::*; #(
  parameter int unsigned PANEL_WIDTH  = DEF_PANEL_WIDTH,   // 8 to 256
  parameter int unsigned PANEL_HEIGHT = DEF_PANEL_HEIGHT,  // 8 to 64
  parameter int unsigned QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  x_pos_i,
  input  logic [7:0]  y_pos_i,
  input  logic [2:0]  page_sel_i,
  input  logic        paint_color_i,
  input  logic [15:0] pattern_i,
  input  logic [4:0]  span_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  byte_read_o,
  output logic        clipped_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       invert_q;
  logic       reg_hit;

  logic       q_push, q_ready, q_pop, q_valid;
  cmd_t       q_in_cmd, q_out_cmd;
  back_stat_t back_stat;

  // register file: bit 2 of paddr picks the register, low bits are the byte lane
  assign reg_hit = paddr[2] == REG_INVERT_COLORS;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {31'b0, invert_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      invert_q <= pwdata[0];
    end
  end

  // front: take and classify command words
  pfb_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .page_sel_i    (page_sel_i),
    .paint_color_i (paint_color_i),
    .pattern_i     (pattern_i),
    .span_i        (span_i),
    .q_ready_i     (q_ready),
    .stat_i        (back_stat),
    .q_push_o      (q_push),
    .q_cmd_o       (q_in_cmd)
  );

  // decoupling queue between front and back
  pfb_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in_cmd),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_out_cmd)
  );

  // back: store, per-pixel read-modify-write, sweeps, result register
  pfb_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .invert_i    (invert_q),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_out_cmd),
    .q_pop_o     (q_pop),
    .stat_o      (back_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .byte_read_o (byte_read_o),
    .clipped_o   (clipped_o)
  );

endmodule

[hw/rtl/pfb_front.sv]
module pfb_front import pfb_pkg::*; #(
  parameter int unsigned PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int unsigned PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] kind_i,
  input  logic [7:0] x_pos_i,
  input  logic [7:0] y_pos_i,
  input  logic [2:0] page_sel_i,
  input  logic       paint_color_i,
  input  logic [15:0] pattern_i,
  input  logic [4:0] span_i,
  input  logic       q_ready_i,
  input  back_stat_t stat_i,
  output logic       q_push_o,
  output cmd_t       q_cmd_o
);

  localparam int unsigned PAGES = (PANEL_HEIGHT + 7) / 8;

  logic row_off;
  logic read_off;

  assign row_off  = {1'b0, y_pos_i} >= 9'(PANEL_HEIGHT);
  assign read_off = ({1'b0, x_pos_i} >= 9'(PANEL_WIDTH)) ||
                    ({1'b0, page_sel_i} >= 4'(PAGES));

  always_comb begin
    q_cmd_o.op      = OP_NOP;
    q_cmd_o.opaque  = 1'b0;
    q_cmd_o.color   = paint_color_i;
    q_cmd_o.pattern = pattern_i;
    q_cmd_o.span    = (span_i > MAX_SPAN) ? MAX_SPAN : span_i;
    q_cmd_o.x       = x_pos_i;
    q_cmd_o.page    = y_pos_i[5:3];
    q_cmd_o.row_bit = y_pos_i[2:0];
    q_cmd_o.off     = row_off;
    case (kind_i)
      KIND_PIXEL: begin
        // single pixel is a one-wide transparent run with its bit set
        q_cmd_o.op      = OP_SEG;
        q_cmd_o.pattern = FIRST_PIXEL;
        q_cmd_o.span    = 5'd1;
      end
      KIND_SEG_TRANSP: begin
        q_cmd_o.op = OP_SEG;
      end
      KIND_SEG_OPAQUE: begin
        q_cmd_o.op     = OP_SEG;
        q_cmd_o.opaque = 1'b1;
      end
      KIND_FILL: begin
        q_cmd_o.op = OP_FILL;
      end
      KIND_READ: begin
        q_cmd_o.op   = OP_READ;
        q_cmd_o.page = page_sel_i;
        q_cmd_o.off  = read_off;
      end
      default: begin
        q_cmd_o.op = OP_NOP;
      end
    endcase
  end

  assign in_ready_o = q_ready_i && !stat_i.init_busy;
  assign q_push_o   = in_valid_i && in_ready_o;

endmodule

[hw/rtl/pfb_cmd_fifo.sv]
module pfb_cmd_fifo import pfb_pkg::*; #(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign ready_o = cnt_q != CW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[hw/rtl/pfb_back.sv]
module pfb_back import pfb_pkg::*; #(
  parameter int unsigned PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int unsigned PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       invert_i,
  input  logic       q_valid_i,
  input  cmd_t       q_cmd_i,
  output logic       q_pop_o,
  output back_stat_t stat_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] byte_read_o,
  output logic       clipped_o
);

  localparam int unsigned PAGES = (PANEL_HEIGHT + 7) / 8;
  localparam int unsigned DEPTH = PANEL_WIDTH * PAGES;
  localparam int unsigned AW    = $clog2(DEPTH);

  back_state_e   state_q, state_d;
  cmd_t          cur_q;
  logic [AW-1:0] base_q;
  logic [3:0]    idx_q, idx_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic          clip_q, clip_d;
  logic          p1_valid_q, p1_valid_d;
  logic [AW-1:0] p1_addr_q;
  logic [7:0]    p1_mask_q;
  logic          p1_val_q;
  logic [7:0]    rd_data_q;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q;
  logic          out_clip_q;
  logic [7:0]    store_q [DEPTH];

  // per-pixel decode for the current run position
  logic [8:0]    col;
  logic          pix_on, pix_paint, pix_clip, pix_wr, pix_val, last_pix;
  logic [AW-1:0] pix_addr;
  logic          sweep_last;

  // control
  logic          seg_step, sweep_wr, rd_en, wr_en, out_free, out_load;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    wr_data, sweep_val, merged;

  assign col       = {1'b0, cur_q.x} + 9'(idx_q);
  assign pix_on    = cur_q.pattern[4'd15 - idx_q];
  assign pix_paint = pix_on || cur_q.opaque;
  assign pix_clip  = pix_paint && ((col >= 9'(PANEL_WIDTH)) || cur_q.off);
  assign pix_wr    = pix_paint && !pix_clip;
  assign pix_val   = cur_q.color ^ invert_i ^ !pix_on;
  assign pix_addr  = base_q + AW'(col);
  assign last_pix  = {1'b0, idx_q} == (cur_q.span - 5'd1);
  assign sweep_last = sweep_q == AW'(DEPTH - 1);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_cmd_i.op)
            OP_SEG:  state_d = (q_cmd_i.span == '0) ? ST_FIN : ST_SEG;
            OP_READ: state_d = ST_READ;
            OP_FILL: state_d = ST_FILL;
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_SEG: begin
        if (last_pix) state_d = ST_FIN;
      end
      ST_READ: begin
        state_d = ST_FIN;
      end
      ST_FILL: begin
        if (sweep_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop_o   = (state_q == ST_IDLE) && q_valid_i;
    seg_step  = state_q == ST_SEG;
    sweep_wr  = (state_q == ST_CLEAR) || (state_q == ST_FILL);
    sweep_val = ((state_q == ST_FILL) && cur_q.color) ? FILL_WHITE : FILL_BLACK;
    rd_en     = (seg_step && pix_wr) || ((state_q == ST_READ) && !cur_q.off);
    rd_addr   = seg_step ? pix_addr : base_q + AW'(cur_q.x);
    out_load  = (state_q == ST_FIN) && out_free;
    stat_o.init_busy = state_q == ST_CLEAR;
  end

  // write side: sweep, or the second half of a pixel read-modify-write
  assign merged  = p1_val_q ? (rd_data_q | p1_mask_q) : (rd_data_q & ~p1_mask_q);
  assign wr_en   = sweep_wr || p1_valid_q;
  assign wr_addr = sweep_wr ? sweep_q : p1_addr_q;
  assign wr_data = sweep_wr ? sweep_val : merged;

  always_comb begin
    sweep_d     = sweep_q;
    idx_d       = idx_q;
    clip_d      = clip_q;
    p1_valid_d  = seg_step && pix_wr;
    out_valid_d = out_valid_q;
    if (q_pop_o) begin
      sweep_d = '0;
      idx_d   = '0;
      clip_d  = (q_cmd_i.op == OP_READ) && q_cmd_i.off;
    end else begin
      if (sweep_wr) sweep_d = sweep_last ? '0 : sweep_q + 1'b1;
      if (seg_step) begin
        idx_d  = idx_q + 4'd1;
        clip_d = clip_q || pix_clip;
      end
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      idx_q       <= '0;
      clip_q      <= 1'b0;
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      idx_q       <= idx_d;
      clip_q      <= clip_d;
      p1_valid_q  <= p1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q  <= q_cmd_i;
      base_q <= AW'(32'(q_cmd_i.page) * 32'(PANEL_WIDTH));
    end
    if (seg_step) begin
      p1_addr_q <= pix_addr;
      p1_mask_q <= 8'b1 << cur_q.row_bit;
      p1_val_q  <= pix_val;
    end
    if (out_load) begin
      out_byte_q <= ((cur_q.op == OP_READ) && !clip_q) ? rd_data_q : FILL_BLACK;
      out_clip_q <= clip_q;
    end
  end

  // frame store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= store_q[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign byte_read_o = out_byte_q;
  assign clipped_o   = out_clip_q;

endmodule

[hw/rtl/pfb_chk.sv]
module pfb_chk import pfb_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  byte_read_o,
  input logic        clipped_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // a held result word keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(byte_read_o) && $stable(clipped_o))
    else $error("result word changed while stalled");

  // a clipped result never carries data
  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |-> byte_read_o == 8'h00)
    else $error("clipped result with nonzero byte");

  // store clearing after reset blocks new words
  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("word taken during store clear");

  // register readback follows the last write
  a_reg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[2] == REG_INVERT_COLORS) |=>
      (paddr[2] != REG_INVERT_COLORS) || (prdata[0] == $past(pwdata[0])))
    else $error("invert register readback mismatch");

endmodule

bind page_framebuffer_draw_engine_top pfb_chk u_chk (.*);
